### rtl/assert_macros.svh
// Assertion macros shared by the upscaler RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ASSERT_SAME_CYCLE(label, trigger, expected, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (trigger) |-> (expected)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define ASSERT_NEXT_CYCLE(label, trigger, expected, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (trigger) |=> (expected)) else $error(msg);

`endif

### rtl/upscl_pkg.sv
// Shared types, constants and helpers of the integer pixel upscaler.
// No dependencies; every module of the block imports this package.
package upscl_pkg;

   // Sizes of the interface fields
   localparam int unsigned DEFAULT_MAX_SCALE = 16;
   localparam int unsigned MAX_DIMENSION     = 4096;
   localparam int unsigned COORD_WIDTH       = $clog2(MAX_DIMENSION);
   localparam int unsigned DIM_WIDTH         = 12;
   localparam int unsigned POS_WIDTH         = 5;
   localparam int unsigned CHAN_WIDTH        = 8;
   localparam int unsigned WORD_WIDTH        = 32;
   localparam int unsigned SPAN_LEN_WIDTH    = 5;
   localparam int unsigned CSR_INDEX_WIDTH   = 3;
   localparam int unsigned CSR_DATA_WIDTH    = 12;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RED_POSITION   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GREEN_POSITION = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLUE_POSITION  = 3'd6;

   // Register values after reset
   localparam logic [DIM_WIDTH-1:0] RESET_WINDOW_WIDTH   = 12'd640;
   localparam logic [DIM_WIDTH-1:0] RESET_WINDOW_HEIGHT  = 12'd480;
   localparam logic [DIM_WIDTH-1:0] RESET_SOURCE_WIDTH   = 12'd1;
   localparam logic [DIM_WIDTH-1:0] RESET_SOURCE_HEIGHT  = 12'd1;
   localparam logic [POS_WIDTH-1:0] RESET_RED_POSITION   = 5'd16;
   localparam logic [POS_WIDTH-1:0] RESET_GREEN_POSITION = 5'd8;
   localparam logic [POS_WIDTH-1:0] RESET_BLUE_POSITION  = 5'd0;

   // Background level of every channel when alpha is zero
   localparam logic [CHAN_WIDTH-1:0] BG_CHANNEL = 8'h80;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SETUP,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;
      logic scale_init;
      logic scale_step;
      logic scale_commit;
      logic setup;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic frame_start;
      logic scale_done;
      logic out_free;
      logic span_last;
   } status_type;

   // Shift one channel byte into place; bits above the word are dropped
   function automatic logic [WORD_WIDTH-1:0] place_byte(
      input logic [CHAN_WIDTH-1:0] value,
      input logic [POS_WIDTH-1:0]  pos
   );
      logic [WORD_WIDTH-1:0] wide;
      wide = {{(WORD_WIDTH-CHAN_WIDTH){1'b0}}, value};
      return wide << pos;
   endfunction

endpackage

### rtl/upscl_ctrl.sv
// Controller of the upscaler: sequences accept, scale search, span setup and span output.
// Depends on upscl_pkg for the state, command and status types.
module upscl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  upscl_pkg::status_type  status,
   output upscl_pkg::cmd_type     cmd
);
   import upscl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.frame_start ? ST_SCALE : ST_SETUP;
            end
         end
         ST_SCALE: begin
            if (status.scale_done) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.span_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive commands and the input stall
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.load_item  = req_valid;
            cmd.scale_init = req_valid && status.frame_start;
         end
         ST_SCALE: begin
            cmd.scale_step   = !status.scale_done;
            cmd.scale_commit = status.scale_done;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/upscl_dp.sv
// Datapath of the upscaler: configuration registers, pixel packing, raster counters,
// iterative scale search, span coordinates and the output register. Uses upscl_pkg.
module upscl_dp #(
   parameter int unsigned MAX_SCALE = upscl_pkg::DEFAULT_MAX_SCALE
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write,
   input  logic [upscl_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [upscl_pkg::CSR_DATA_WIDTH-1:0]       csr_data,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_red,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_green,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_blue,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_alpha,
   input  upscl_pkg::cmd_type                         cmd,
   output upscl_pkg::status_type                      status,
   input  logic                                       rsp_stall,
   output logic                                       rsp_valid,
   output logic [upscl_pkg::COORD_WIDTH-1:0]          rsp_image_row,
   output logic [upscl_pkg::COORD_WIDTH-1:0]          rsp_span_start,
   output logic [upscl_pkg::SPAN_LEN_WIDTH-1:0]       rsp_span_length,
   output logic [upscl_pkg::WORD_WIDTH-1:0]           rsp_pixel_word,
   output logic signed [upscl_pkg::DIM_WIDTH-1:0]     rsp_origin_x,
   output logic signed [upscl_pkg::DIM_WIDTH-1:0]     rsp_origin_y,
   output logic                                       rsp_last
);
   import upscl_pkg::*;

   localparam int unsigned ScaleWidth = $clog2(MAX_SCALE + 1);
   localparam int unsigned AccWidth   = DIM_WIDTH + ScaleWidth;
   localparam logic [ScaleWidth-1:0] ScaleMax = ScaleWidth'(MAX_SCALE);
   localparam logic [ScaleWidth-1:0] ScaleOne = ScaleWidth'(1);

   // Configuration
   logic [DIM_WIDTH-1:0] window_width_ff, window_height_ff;
   logic [DIM_WIDTH-1:0] source_width_ff, source_height_ff;
   logic [POS_WIDTH-1:0] red_position_ff, green_position_ff, blue_position_ff;

   // Item and frame state
   logic [WORD_WIDTH-1:0]       word_ff, word_in;
   logic [DIM_WIDTH-1:0]        column_ff, row_ff;
   logic [ScaleWidth-1:0]       scale_ff;
   logic signed [DIM_WIDTH-1:0] place_x_ff, place_y_ff;

   // Scale search
   logic [ScaleWidth-1:0] iter_scale_ff;
   logic [AccWidth-1:0]   acc_x_ff, acc_y_ff;
   logic [AccWidth:0]     acc_x_in, acc_y_in;
   logic                  step_ok;

   // Span generation
   logic [COORD_WIDTH-1:0]       col_start_ff, row_base_ff;
   logic [ScaleWidth-1:0]        k_ff;
   logic [DIM_WIDTH+ScaleWidth-1:0] col_product, row_product;

   logic [DIM_WIDTH-1:0] source_width_one, source_height_one;
   logic [DIM_WIDTH-1:0] place_x_in, place_y_in;
   logic                 column_wrap, row_wrap;
   logic                 rsp_valid_ff;

   // A zero source dimension acts as one
   assign source_width_one  = (source_width_ff == '0)  ? DIM_WIDTH'(1) : source_width_ff;
   assign source_height_one = (source_height_ff == '0) ? DIM_WIDTH'(1) : source_height_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff   <= RESET_WINDOW_WIDTH;
         window_height_ff  <= RESET_WINDOW_HEIGHT;
         source_width_ff   <= RESET_SOURCE_WIDTH;
         source_height_ff  <= RESET_SOURCE_HEIGHT;
         red_position_ff   <= RESET_RED_POSITION;
         green_position_ff <= RESET_GREEN_POSITION;
         blue_position_ff  <= RESET_BLUE_POSITION;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_WIDTH:   window_width_ff   <= csr_data[DIM_WIDTH-1:0];
            CSR_WINDOW_HEIGHT:  window_height_ff  <= csr_data[DIM_WIDTH-1:0];
            CSR_SOURCE_WIDTH:   source_width_ff   <= csr_data[DIM_WIDTH-1:0];
            CSR_SOURCE_HEIGHT:  source_height_ff  <= csr_data[DIM_WIDTH-1:0];
            CSR_RED_POSITION:   red_position_ff   <= csr_data[POS_WIDTH-1:0];
            CSR_GREEN_POSITION: green_position_ff <= csr_data[POS_WIDTH-1:0];
            CSR_BLUE_POSITION:  blue_position_ff  <= csr_data[POS_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pack the pixel, or the grey background when alpha is zero
   always_comb begin
      if (req_alpha != '0) begin
         word_in = place_byte(req_red, red_position_ff)
                 | place_byte(req_green, green_position_ff)
                 | place_byte(req_blue, blue_position_ff);
      end else begin
         word_in = place_byte(BG_CHANNEL, red_position_ff)
                 | place_byte(BG_CHANNEL, green_position_ff)
                 | place_byte(BG_CHANNEL, blue_position_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         word_ff <= word_in;
      end
   end

   // Scale search: grow the scale, up to MAX_SCALE, while both scaled dimensions fit the window
   assign acc_x_in = {1'b0, acc_x_ff} + (AccWidth+1)'(source_width_one);
   assign acc_y_in = {1'b0, acc_y_ff} + (AccWidth+1)'(source_height_one);
   assign step_ok  = (iter_scale_ff < ScaleMax)
                   && (acc_x_in <= (AccWidth+1)'(window_width_ff))
                   && (acc_y_in <= (AccWidth+1)'(window_height_ff));

   always_ff @(posedge clock) begin
      if (cmd.scale_init) begin
         iter_scale_ff <= ScaleOne;
         acc_x_ff      <= AccWidth'(source_width_one);
         acc_y_ff      <= AccWidth'(source_height_one);
      end else if (cmd.scale_step) begin
         iter_scale_ff <= iter_scale_ff + ScaleOne;
         acc_x_ff      <= acc_x_in[AccWidth-1:0];
         acc_y_ff      <= acc_y_in[AccWidth-1:0];
      end
   end

   // Centre the scaled image; the difference wraps to 12 bits
   assign place_x_in = {1'b0, window_width_ff[DIM_WIDTH-1:1]} - acc_x_ff[DIM_WIDTH:1];
   assign place_y_in = {1'b0, window_height_ff[DIM_WIDTH-1:1]} - acc_y_ff[DIM_WIDTH:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= ScaleOne;
         place_x_ff <= '0;
         place_y_ff <= '0;
      end else if (cmd.scale_commit) begin
         scale_ff   <= iter_scale_ff;
         place_x_ff <= place_x_in;
         place_y_ff <= place_y_in;
      end
   end

   // Raster counters wrap against the current source dimensions
   assign column_wrap = ({1'b0, column_ff} + 1'b1) >= {1'b0, source_width_one};
   assign row_wrap    = ({1'b0, row_ff} + 1'b1) >= {1'b0, source_height_one};

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else if (cmd.setup) begin
         if (column_wrap) begin
            column_ff <= '0;
            row_ff    <= row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            column_ff <= column_ff + 1'b1;
         end
      end
   end

   // Destination coordinates of the first span, wrapping at MAX_DIMENSION
   assign col_product = {{ScaleWidth{1'b0}}, column_ff} * {{DIM_WIDTH{1'b0}}, scale_ff};
   assign row_product = {{ScaleWidth{1'b0}}, row_ff} * {{DIM_WIDTH{1'b0}}, scale_ff};

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         col_start_ff <= col_product[COORD_WIDTH-1:0];
         row_base_ff  <= row_product[COORD_WIDTH-1:0];
         k_ff         <= '0;
      end else if (cmd.emit) begin
         k_ff <= k_ff + ScaleOne;
      end
   end

   // Output register: load a span when the slot is free, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_image_row   <= row_base_ff + COORD_WIDTH'(k_ff);
         rsp_span_start  <= col_start_ff;
         rsp_span_length <= SPAN_LEN_WIDTH'(scale_ff);
         rsp_pixel_word  <= word_ff;
         rsp_origin_x    <= place_x_ff;
         rsp_origin_y    <= place_y_ff;
         rsp_last        <= status.span_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status to the controller
   assign status.frame_start = (column_ff == '0) && (row_ff == '0);
   assign status.scale_done  = !step_ok;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign status.span_last   = ({1'b0, k_ff} + 1'b1) == {1'b0, scale_ff};

endmodule

### rtl/integer_pixel_upscaler_top.sv
// Integer nearest-neighbour upscaler with centred letterbox placement. Source RGBA pixels
// arrive in raster order, one per req beat; each one leaves as scale rsp beats, one span of
// scale identical pixels per destination row it covers, the final one marked by rsp_last.
// The first pixel of a frame latches the scale (the lesser of the window-to-source ratios,
// clamped to 1..MAX_SCALE) and the centred origin; a window or source size change reaches these at
// the next frame start. An item passes through accept, span setup and one span per destination
// row from the single output register, plus a scale search at a frame start, which tries one
// candidate scale per cycle with an adder and compare pair per axis. rsp stalls stretch the span
// phase; the next pixel is taken while the final span still waits in the output register.
// Depends on upscl_pkg, upscl_ctrl, upscl_dp and assert_macros.svh.
`include "assert_macros.svh"

module integer_pixel_upscaler_top #(
   parameter int unsigned MAX_SCALE = upscl_pkg::DEFAULT_MAX_SCALE
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write,
   input  logic [upscl_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [upscl_pkg::CSR_DATA_WIDTH-1:0]       csr_data,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_red,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_green,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_blue,
   input  logic [upscl_pkg::CHAN_WIDTH-1:0]           req_alpha,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [upscl_pkg::COORD_WIDTH-1:0]          rsp_image_row,
   output logic [upscl_pkg::COORD_WIDTH-1:0]          rsp_span_start,
   output logic [upscl_pkg::SPAN_LEN_WIDTH-1:0]       rsp_span_length,
   output logic [upscl_pkg::WORD_WIDTH-1:0]           rsp_pixel_word,
   output logic signed [upscl_pkg::DIM_WIDTH-1:0]     rsp_origin_x,
   output logic signed [upscl_pkg::DIM_WIDTH-1:0]     rsp_origin_y,
   output logic                                       rsp_last
);
   import upscl_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence each pixel
   upscl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Compute and hold spans
   upscl_dp #(
      .MAX_SCALE (MAX_SCALE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_image_row   (rsp_image_row),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_length (rsp_span_length),
      .rsp_pixel_word  (rsp_pixel_word),
      .rsp_origin_x    (rsp_origin_x),
      .rsp_origin_y    (rsp_origin_y),
      .rsp_last        (rsp_last)
   );

   // No new pixel while the current one still owes spans
   `ASSERT_SAME_CYCLE(a_no_accept_mid_item, rsp_valid && !rsp_last, req_stall, "pixel accepted mid-item")

   // A taken span that is not the last is followed at once by the next one
   `ASSERT_NEXT_CYCLE(a_spans_back_to_back, rsp_valid && !rsp_stall && !rsp_last, rsp_valid, "gap between spans")

   // Spans of one pixel step down one row and keep their column
   `ASSERT_NEXT_CYCLE(a_span_rows_step, rsp_valid && !rsp_stall && !rsp_last, (rsp_image_row == COORD_WIDTH'($past(rsp_image_row) + 1'b1)) && (rsp_span_start == $past(rsp_span_start)), "span rows out of step")

endmodule

### sim/integer_pixel_upscaler_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for integer_pixel_upscaler_top: directed and random pixels
// checked span by span against a local model of scale, placement and packing.
// Depends on upscl_pkg and the upscaler RTL only.
module integer_pixel_upscaler_top_tb;
   import upscl_pkg::*;

   localparam real CLOCK_HALF     = 2.0;
   localparam int  RESET_CYCLES   = 11;
   localparam int  SETTLE_CYCLES  = 40;
   localparam int  HOLD_CYCLES    = 250;
   localparam int  TIMEOUT_CYCLES = 400000;
   localparam int  REPORT_LIMIT   = 10;
   localparam int  PHASE_PIXELS   = 7;
   localparam int  WRAP_PIXELS    = 260;

   typedef enum logic [1:0] {
      IDLE_SEND_LIGHT,
      IDLE_RECV_LIGHT,
      IDLE_NONE
   } idle_mode_type;

   // One destination span as it should leave the block
   typedef struct {
      logic [COORD_WIDTH-1:0]    image_row;
      logic [COORD_WIDTH-1:0]    span_start;
      logic [SPAN_LEN_WIDTH-1:0] span_length;
      logic [WORD_WIDTH-1:0]     pixel_word;
      logic [DIM_WIDTH-1:0]      origin_x;
      logic [DIM_WIDTH-1:0]      origin_y;
      logic                      last;
   } dest_span_type;

   // One line of the directed sequence: a register write or a pixel
   typedef struct {
      bit                         is_write;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  value;
      logic [CHAN_WIDTH-1:0]      red, green, blue, alpha;
      bit                         known;
      logic [WORD_WIDTH-1:0]      known_word;
      logic [SPAN_LEN_WIDTH-1:0]  known_length;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]       csr_index = CSR_WINDOW_WIDTH;
   logic [CSR_DATA_WIDTH-1:0]        csr_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [CHAN_WIDTH-1:0]            req_red = '0;
   logic [CHAN_WIDTH-1:0]            req_green = '0;
   logic [CHAN_WIDTH-1:0]            req_blue = '0;
   logic [CHAN_WIDTH-1:0]            req_alpha = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [COORD_WIDTH-1:0]           rsp_image_row;
   logic [COORD_WIDTH-1:0]           rsp_span_start;
   logic [SPAN_LEN_WIDTH-1:0]        rsp_span_length;
   logic [WORD_WIDTH-1:0]            rsp_pixel_word;
   logic signed [DIM_WIDTH-1:0]      rsp_origin_x;
   logic signed [DIM_WIDTH-1:0]      rsp_origin_y;
   logic                             rsp_last;

   // Shadow registers and raster state of the local model
   logic [DIM_WIDTH-1:0]      win_w = RESET_WINDOW_WIDTH;
   logic [DIM_WIDTH-1:0]      win_h = RESET_WINDOW_HEIGHT;
   logic [DIM_WIDTH-1:0]      src_w = RESET_SOURCE_WIDTH;
   logic [DIM_WIDTH-1:0]      src_h = RESET_SOURCE_HEIGHT;
   logic [POS_WIDTH-1:0]      red_pos = RESET_RED_POSITION;
   logic [POS_WIDTH-1:0]      green_pos = RESET_GREEN_POSITION;
   logic [POS_WIDTH-1:0]      blue_pos = RESET_BLUE_POSITION;
   logic [DIM_WIDTH-1:0]      col_cnt = '0;
   logic [DIM_WIDTH-1:0]      row_cnt = '0;
   logic [SPAN_LEN_WIDTH-1:0] scale = 5'd1;
   logic [DIM_WIDTH-1:0]      place_x = '0;
   logic [DIM_WIDTH-1:0]      place_y = '0;
   bit                        frame_began = 1'b0;

   dest_span_type pending_spans[$];

   idle_mode_type idle_mode = IDLE_SEND_LIGHT;
   int         send_idle_pct = 7;
   int         recv_idle_pct = 77;
   int         hold_left = 0;
   bit         hold_done = 1'b0;

   int mismatch_count = 0;
   int spans_checked = 0;
   int pixels_sent = 0;
   int frames_started = 0;
   int reg_writes = 0;

   integer_pixel_upscaler_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_image_row   (rsp_image_row),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_length (rsp_span_length),
      .rsp_pixel_word  (rsp_pixel_word),
      .rsp_origin_x    (rsp_origin_x),
      .rsp_origin_y    (rsp_origin_y),
      .rsp_last        (rsp_last)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("Timeout with %0d spans still awaited", pending_spans.size());
      $display("Test completed with failures");
      $finish;
   end

   // Work out the spans one source pixel produces and advance the raster counters
   task automatic upscale_pixel(input logic [CHAN_WIDTH-1:0] red, green, blue, alpha);
      int unsigned eff_w, eff_h, ratio_x, ratio_y, step, k;
      logic [WORD_WIDTH-1:0] word;
      dest_span_type span;
      eff_w = (src_w == 0) ? 1 : src_w;
      eff_h = (src_h == 0) ? 1 : src_h;
      frame_began = (col_cnt == 0 && row_cnt == 0);
      // latch scale and centred placement at a frame start
      if (frame_began) begin
         ratio_x = win_w / eff_w;
         ratio_y = win_h / eff_h;
         step = (ratio_x < ratio_y) ? ratio_x : ratio_y;
         if (step < 1) step = 1;
         if (step > DEFAULT_MAX_SCALE) step = DEFAULT_MAX_SCALE;
         scale = SPAN_LEN_WIDTH'(step);
         place_x = DIM_WIDTH'((win_w >> 1) - ((eff_w * step) >> 1));
         place_y = DIM_WIDTH'((win_h >> 1) - ((eff_h * step) >> 1));
         frames_started++;
      end
      // pack the channels; bits shifted past the word are dropped
      if (alpha != 0)
         word = (WORD_WIDTH'(red) << red_pos) | (WORD_WIDTH'(green) << green_pos) |
                (WORD_WIDTH'(blue) << blue_pos);
      else
         word = (WORD_WIDTH'(BG_CHANNEL) << red_pos) | (WORD_WIDTH'(BG_CHANNEL) << green_pos) |
                (WORD_WIDTH'(BG_CHANNEL) << blue_pos);
      step = 32'(scale);
      for (k = 0; k < step; k++) begin
         span.image_row   = COORD_WIDTH'((row_cnt * step + k) % MAX_DIMENSION);
         span.span_start  = COORD_WIDTH'((col_cnt * step) % MAX_DIMENSION);
         span.span_length = scale;
         span.pixel_word  = word;
         span.origin_x    = place_x;
         span.origin_y    = place_y;
         span.last        = (k + 1 == step);
         pending_spans.push_back(span);
      end
      // advance the raster against the current source size
      if (col_cnt + 1 >= eff_w) begin
         col_cnt = '0;
         if (row_cnt + 1 >= eff_h)
            row_cnt = '0;
         else
            row_cnt = row_cnt + 1'b1;
      end else begin
         col_cnt = col_cnt + 1'b1;
      end
   endtask

   // Offer one pixel beat, hold it until taken, then predict its spans
   task automatic offer_pixel(input logic [CHAN_WIDTH-1:0] red, green, blue, alpha,
                              output int first);
      bit taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      req_alpha <= alpha;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      first = pending_spans.size();
      upscale_pixel(red, green, blue, alpha);
      pixels_sent++;
   endtask

   task automatic offer_random_pixel();
      int first;
      logic [CHAN_WIDTH-1:0] alpha;
      alpha = ($urandom_range(0, 3) == 0) ? 8'h00 : CHAN_WIDTH'($urandom_range(1, 255));
      offer_pixel(CHAN_WIDTH'($urandom), CHAN_WIDTH'($urandom), CHAN_WIDTH'($urandom),
                  alpha, first);
   endtask

   // Stop offering and wait for every awaited span, plus the block's own latency
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_spans.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the caller lowers csr_write after the last of a burst
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      case (index)
         CSR_WINDOW_WIDTH:   win_w = value;
         CSR_WINDOW_HEIGHT:  win_h = value;
         CSR_SOURCE_WIDTH:   src_w = value;
         CSR_SOURCE_HEIGHT:  src_h = value;
         CSR_RED_POSITION:   red_pos = value[POS_WIDTH-1:0];
         CSR_GREEN_POSITION: green_pos = value[POS_WIDTH-1:0];
         CSR_BLUE_POSITION:  blue_pos = value[POS_WIDTH-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   function automatic logic [DIM_WIDTH-1:0] pick_window_size();
      case ($urandom_range(0, 7))
         0: return 12'd1;
         1: return 12'd4095;
         default: return DIM_WIDTH'($urandom_range(1, 96));
      endcase
   endfunction

   // Mostly small sources so frames wrap often; now and then zero or huge
   function automatic logic [DIM_WIDTH-1:0] pick_source_size();
      case ($urandom_range(0, 9))
         0: return 12'd0;
         1: return DIM_WIDTH'($urandom_range(1, 4095));
         default: return DIM_WIDTH'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic write_random_setting();
      drain();
      write_register(CSR_WINDOW_WIDTH, pick_window_size());
      write_register(CSR_WINDOW_HEIGHT, pick_window_size());
      write_register(CSR_SOURCE_WIDTH, pick_source_size());
      write_register(CSR_SOURCE_HEIGHT, pick_source_size());
      write_register(CSR_RED_POSITION, CSR_DATA_WIDTH'($urandom_range(0, 31)));
      write_register(CSR_GREEN_POSITION, CSR_DATA_WIDTH'($urandom_range(0, 31)));
      write_register(CSR_BLUE_POSITION, CSR_DATA_WIDTH'($urandom_range(0, 31)));
      csr_write <= 1'b0;
   endtask

   function automatic stimulus_row_type pixel_row(
      input logic [CHAN_WIDTH-1:0] red, green, blue, alpha,
      input bit known = 1'b0,
      input logic [WORD_WIDTH-1:0] known_word = '0,
      input logic [SPAN_LEN_WIDTH-1:0] known_length = '0
   );
      stimulus_row_type row;
      row = '{default: '0};
      row.red          = red;
      row.green        = green;
      row.blue         = blue;
      row.alpha        = alpha;
      row.known        = known;
      row.known_word   = known_word;
      row.known_length = known_length;
      return row;
   endfunction

   function automatic stimulus_row_type reg_row(input logic [CSR_INDEX_WIDTH-1:0] index,
                                                input logic [CSR_DATA_WIDTH-1:0] value);
      stimulus_row_type row;
      row = '{default: '0};
      row.is_write = 1'b1;
      row.index    = index;
      row.value    = value;
      return row;
   endfunction

   task automatic check_field(input string field, input logic [WORD_WIDTH-1:0] want,
                              input logic [WORD_WIDTH-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch in %s at span %0d: expected 0x%0h, got 0x%0h",
                     field, spans_checked, want, got);
      end
   endtask

   // Receiver: random stall, plus one long hold when the receiver-light idle mode begins
   always @(posedge clock) begin
      if (!hold_done && idle_mode == IDLE_RECV_LIGHT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Check each span beat against the oldest awaited one; sample mid-cycle
   always @(negedge clock) begin : span_monitor
      dest_span_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_spans.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Span beat with nothing awaited: row %0d start %0d word 0x%0h",
                        rsp_image_row, rsp_span_start, rsp_pixel_word);
         end else begin
            due = pending_spans.pop_front();
            check_field("image_row", WORD_WIDTH'(due.image_row), WORD_WIDTH'(rsp_image_row));
            check_field("span_start", WORD_WIDTH'(due.span_start),
                        WORD_WIDTH'(rsp_span_start));
            check_field("span_length", WORD_WIDTH'(due.span_length),
                        WORD_WIDTH'(rsp_span_length));
            check_field("pixel_word", due.pixel_word, rsp_pixel_word);
            check_field("origin_x", WORD_WIDTH'(due.origin_x),
                        WORD_WIDTH'($unsigned(rsp_origin_x)));
            check_field("origin_y", WORD_WIDTH'(due.origin_y),
                        WORD_WIDTH'($unsigned(rsp_origin_y)));
            check_field("last", WORD_WIDTH'(due.last), WORD_WIDTH'(rsp_last));
            spans_checked++;
         end
      end
   end

   initial begin : stimulus
      stimulus_row_type rows[$];
      int            first, i, p, k;
      bit            writing;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // After reset: 640x480 window, 1x1 source, so every pixel is a frame at scale 16
      rows.push_back(pixel_row(8'hff, 8'h00, 8'h00, 8'hff, 1'b1, 32'h00ff0000, 5'd16));
      rows.push_back(pixel_row(8'h12, 8'h34, 8'h56, 8'h00, 1'b1, 32'h00808080, 5'd16));
      rows.push_back(pixel_row(8'hff, 8'hff, 8'hff, 8'h01, 1'b1, 32'h00ffffff, 5'd16));
      rows.push_back(pixel_row(8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 32'h00000000, 5'd16));
      rows.push_back(pixel_row(8'h5a, 8'ha5, 8'h3c, 8'h80));
      // shifts past the top byte lose the upper bits, background included
      rows.push_back(reg_row(CSR_RED_POSITION, 12'd24));
      rows.push_back(reg_row(CSR_GREEN_POSITION, 12'd31));
      rows.push_back(reg_row(CSR_BLUE_POSITION, 12'd25));
      rows.push_back(pixel_row(8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 32'hff000000, 5'd16));
      rows.push_back(pixel_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 32'h80000000, 5'd16));
      rows.push_back(pixel_row(8'h01, 8'h01, 8'h01, 8'hff, 1'b1, 32'h83000000, 5'd16));
      // all channels on bit zero overlap
      rows.push_back(reg_row(CSR_RED_POSITION, 12'd0));
      rows.push_back(reg_row(CSR_GREEN_POSITION, 12'd0));
      rows.push_back(reg_row(CSR_BLUE_POSITION, 12'd0));
      rows.push_back(pixel_row(8'h0f, 8'hf0, 8'h00, 8'hff, 1'b1, 32'h000000ff, 5'd16));
      // scale clamped up to one; the placement goes negative and wraps
      rows.push_back(reg_row(CSR_RED_POSITION, 12'd16));
      rows.push_back(reg_row(CSR_GREEN_POSITION, 12'd8));
      rows.push_back(reg_row(CSR_BLUE_POSITION, 12'd0));
      rows.push_back(reg_row(CSR_WINDOW_WIDTH, 12'd1));
      rows.push_back(reg_row(CSR_WINDOW_HEIGHT, 12'd4095));
      rows.push_back(reg_row(CSR_SOURCE_WIDTH, 12'd4095));
      rows.push_back(reg_row(CSR_SOURCE_HEIGHT, 12'd1));
      rows.push_back(pixel_row(8'h80, 8'h40, 8'h20, 8'hff, 1'b1, 32'h00804020, 5'd1));
      rows.push_back(pixel_row(8'h7e, 8'h81, 8'hc3, 8'h00));
      rows.push_back(pixel_row(8'h3c, 8'h18, 8'he7, 8'h42));
      // zero source size acts as one; the column counter wraps on the next pixel
      rows.push_back(reg_row(CSR_WINDOW_WIDTH, 12'd4095));
      rows.push_back(reg_row(CSR_SOURCE_WIDTH, 12'd0));
      rows.push_back(reg_row(CSR_SOURCE_HEIGHT, 12'd0));
      rows.push_back(pixel_row(8'haa, 8'h55, 8'h99, 8'hfe));
      rows.push_back(pixel_row(8'h00, 8'hff, 8'h00, 8'hff, 1'b1, 32'h0000ff00, 5'd16));
      // full-size source, then shrink it mid-frame
      rows.push_back(reg_row(CSR_SOURCE_WIDTH, 12'd4095));
      rows.push_back(reg_row(CSR_SOURCE_HEIGHT, 12'd4095));
      rows.push_back(pixel_row(8'h11, 8'h22, 8'h33, 8'h44));
      rows.push_back(pixel_row(8'hee, 8'hdd, 8'hcc, 8'h00));
      rows.push_back(reg_row(CSR_WINDOW_WIDTH, 12'd100));
      rows.push_back(reg_row(CSR_SOURCE_WIDTH, 12'd3));
      rows.push_back(reg_row(CSR_SOURCE_HEIGHT, 12'd2));
      for (k = 0; k < 5; k++)
         rows.push_back(pixel_row(CHAN_WIDTH'(8'h21 * k), CHAN_WIDTH'(8'hf0 - 8'h11 * k),
                                  CHAN_WIDTH'(8'h0c + k), CHAN_WIDTH'(8'h40 * k)));

      // Walk the directed rows; drain before each burst of register writes
      writing = 1'b0;
      foreach (rows[i]) begin
         if (rows[i].is_write) begin
            if (!writing) begin
               drain();
               writing = 1'b1;
            end
            write_register(rows[i].index, rows[i].value);
         end else begin
            if (writing) begin
               csr_write <= 1'b0;
               writing = 1'b0;
            end
            offer_pixel(rows[i].red, rows[i].green, rows[i].blue, rows[i].alpha, first);
            // where the result is plain to see, the typed value stands
            if (rows[i].known)
               for (p = first; p < pending_spans.size(); p++) begin
                  pending_spans[p].pixel_word  = rows[i].known_word;
                  pending_spans[p].span_length = rows[i].known_length;
               end
         end
      end

      // Random settings; writes land between frames and mid-frame alike
      for (i = 0; i < 6; i++) begin
         if (i == 3) begin
            drain();
            idle_mode     <= IDLE_RECV_LIGHT;
            send_idle_pct <= 77;
            recv_idle_pct <= 7;
         end
         write_random_setting();
         for (k = 0; k < PHASE_PIXELS; k++)
            offer_random_pixel();
      end

      // No idling: latch scale 16 on a two-row frame, then stretch the frame so
      // destination rows run past the coordinate range
      drain();
      idle_mode     <= IDLE_NONE;
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_register(CSR_WINDOW_WIDTH, 12'd4095);
      write_register(CSR_WINDOW_HEIGHT, 12'd4095);
      write_register(CSR_SOURCE_WIDTH, 12'd1);
      write_register(CSR_SOURCE_HEIGHT, 12'd2);
      write_register(CSR_RED_POSITION, CSR_DATA_WIDTH'($urandom_range(0, 31)));
      csr_write <= 1'b0;
      do
         offer_random_pixel();
      while (!frame_began);
      drain();
      write_register(CSR_SOURCE_HEIGHT, 12'd4095);
      csr_write <= 1'b0;
      for (k = 0; k < WRAP_PIXELS; k++)
         offer_random_pixel();

      drain();
      $display("Covered %0d pixels in %0d frame starts, %0d register writes,",
               pixels_sent, frames_started, reg_writes);
      $display("%0d spans checked under three idling mixes and a long receiver hold",
               spans_checked);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
